/* design/bra_pkg.sv */
// Shared constants, codes and control types of the bitmap run allocator.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package bra_pkg;

  localparam int MAP_BYTES  = 512;
  localparam int WORD_W     = 64;
  localparam int WORD_LG    = $clog2(WORD_W);
  localparam int WORD_BYTES = WORD_W / 8;
  localparam int WBYTE_LG   = $clog2(WORD_BYTES);
  localparam int WORDS      = (MAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int WADDR_W    = $clog2(WORDS);
  localparam int CNT_W      = WADDR_W + 1;

  localparam int KIND_W   = 3;
  localparam int BIT_W    = 12;
  localparam int RUN_W    = 13;
  localparam int USED_W   = 10;
  localparam int STATUS_W = 2;

  localparam logic [USED_W-1:0] USED_RESET = USED_W'(512);
  localparam logic [USED_W-1:0] USED_MAX   = USED_W'(MAP_BYTES);

  localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TEST      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_MODIFY,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_run;
    logic rmw_write;
    logic clear_all;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              oor;
    logic              scan_done;
    logic              out_busy;
  } sts_t;

endpackage

`default_nettype wire

/* design/bra_ifs.sv */
// Channel interfaces: operation request, result and configuration write.
// Field widths come from bra_pkg.
`default_nettype none

interface bra_req_if;
  logic                           valid;
  logic                           ready;
  logic [bra_pkg::KIND_W-1:0]     kind;
  logic [bra_pkg::BIT_W-1:0]      bit_index;
  logic [bra_pkg::RUN_W-1:0]      run_length;
  modport source (output valid, kind, bit_index, run_length, input ready);
  modport sink   (input valid, kind, bit_index, run_length, output ready);
endinterface

interface bra_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bra_pkg::STATUS_W-1:0]   status;
  logic [bra_pkg::BIT_W-1:0]      start_index;
  logic                           bit_read;
  modport source (output valid, status, start_index, bit_read, input ready);
  modport sink   (input valid, status, start_index, bit_read, output ready);
endinterface

interface bra_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bra_pkg::USED_W-1:0]     bytes_in_use;
  modport source (output valid, bytes_in_use, input ready);
  modport sink   (input valid, bytes_in_use, output ready);
endinterface

`default_nettype wire

/* design/bra_word_scan.sv */
// Per-word features for the run search: first set bit, free bits at the top
// and lowest start of a run of free bits that fits inside the word. Uses bra_pkg.
`default_nettype none

module bra_word_scan (
  input  logic [bra_pkg::WORD_W-1:0]  word,
  input  logic [bra_pkg::RUN_W-1:0]   want,
  output logic [bra_pkg::WORD_LG:0]   first_one,
  output logic [bra_pkg::WORD_LG:0]   top_zeros,
  output logic                        run_hit,
  output logic [bra_pkg::WORD_LG-1:0] run_pos
);

  localparam int PW = bra_pkg::WORD_LG + 1;

  // free_at[k] bit s: bits s .. s + 2**k - 1 are all free
  logic [bra_pkg::WORD_W-1:0] free_at [bra_pkg::WORD_LG];
  logic [bra_pkg::WORD_W-1:0] fits;

  always_comb begin
    first_one = PW'(bra_pkg::WORD_W);
    for (int i = bra_pkg::WORD_W - 1; i >= 0; i--) begin
      if (word[i]) first_one = PW'(i);
    end
  end

  always_comb begin
    top_zeros = PW'(bra_pkg::WORD_W);
    for (int i = 0; i < bra_pkg::WORD_W; i++) begin
      if (word[i]) top_zeros = PW'(bra_pkg::WORD_W - 1 - i);
    end
  end

  always_comb begin
    free_at[0] = ~word;
    for (int k = 0; k < bra_pkg::WORD_LG - 1; k++) begin
      free_at[k+1] = free_at[k] & (free_at[k] >> (1 << k));
    end
  end

  // AND one segment per set bit of the length, each offset by the lower bits
  always_comb begin
    logic [bra_pkg::WORD_LG-1:0] low_mask;
    fits = '1;
    for (int k = 0; k < bra_pkg::WORD_LG; k++) begin
      low_mask = bra_pkg::WORD_LG'((1 << k) - 1);
      if (want[k]) fits = fits & (free_at[k] >> (want[bra_pkg::WORD_LG-1:0] & low_mask));
    end
  end

  always_comb begin
    run_pos = '0;
    for (int i = bra_pkg::WORD_W - 1; i >= 0; i--) begin
      if (fits[i]) run_pos = bra_pkg::WORD_LG'(i);
    end
    run_hit = (want != '0) && (want[bra_pkg::RUN_W-1:bra_pkg::WORD_LG] == '0) && (|fits);
  end

endmodule

`default_nettype wire

/* design/bra_ctrl.sv */
// Sequencer of the allocator: takes an item, dispatches it to the datapath,
// waits for the scan or the read-modify-write and hands the result out. Uses bra_pkg.
`default_nettype none

module bra_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bra_pkg::sts_t sts,
  output bra_pkg::cmd_t cmd
);

  bra_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bra_pkg::S_IDLE: begin
        if (in_valid) state_next = bra_pkg::S_DISPATCH;
      end
      bra_pkg::S_DISPATCH: begin
        unique case (sts.kind) inside
          bra_pkg::KIND_SEARCH: state_next = bra_pkg::S_SCAN;
          bra_pkg::KIND_SET, bra_pkg::KIND_CLEAR, bra_pkg::KIND_TEST: begin
            state_next = sts.oor ? bra_pkg::S_REPLY : bra_pkg::S_MODIFY;
          end
          default: state_next = bra_pkg::S_REPLY;
        endcase
      end
      bra_pkg::S_SCAN: begin
        if (sts.scan_done) state_next = bra_pkg::S_REPLY;
      end
      bra_pkg::S_MODIFY: state_next = bra_pkg::S_REPLY;
      bra_pkg::S_REPLY: begin
        if (!sts.out_busy) state_next = bra_pkg::S_IDLE;
      end
      default: state_next = bra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      bra_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bra_pkg::S_DISPATCH: begin
        cmd.scan_start = (sts.kind == bra_pkg::KIND_SEARCH);
        cmd.clear_all  = (sts.kind == bra_pkg::KIND_CLEAR_ALL);
      end
      bra_pkg::S_SCAN:   cmd.scan_run  = 1'b1;
      bra_pkg::S_MODIFY: cmd.rmw_write = 1'b1;
      bra_pkg::S_REPLY:  cmd.emit      = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/bra_datapath.sv */
// Datapath: bitmap memory with per-word valid bits, item and config registers,
// the three-stage word scan pipeline and the result register.
// Uses bra_pkg and bra_word_scan.
`default_nettype none

module bra_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  bra_pkg::cmd_t                 cmd,
  output bra_pkg::sts_t                 sts,
  input  logic [bra_pkg::KIND_W-1:0]    in_kind,
  input  logic [bra_pkg::BIT_W-1:0]     in_bit_index,
  input  logic [bra_pkg::RUN_W-1:0]     in_run_length,
  input  logic                          cfg_we,
  input  logic [bra_pkg::USED_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bra_pkg::STATUS_W-1:0]  out_status,
  output logic [bra_pkg::BIT_W-1:0]     out_start_index,
  output logic                          out_bit_read
);

  localparam int PW = bra_pkg::WORD_LG + 1;

  // configuration and held item
  logic [bra_pkg::USED_W-1:0] used_reg;
  logic [bra_pkg::USED_W-1:0] used_eff;
  logic [bra_pkg::USED_W:0]   used_round;
  logic [bra_pkg::CNT_W-1:0]  nwords;
  logic [bra_pkg::KIND_W-1:0] kind_q;
  logic [bra_pkg::BIT_W-1:0]  idx_q;
  logic [bra_pkg::RUN_W-1:0]  want_q;
  logic                       oor;

  // memory
  logic [bra_pkg::WORD_W-1:0]  mem [bra_pkg::WORDS];
  logic [bra_pkg::WORDS-1:0]   wvalid;
  logic [bra_pkg::WADDR_W-1:0] raddr;
  logic [bra_pkg::WADDR_W-1:0] idx_word;
  logic [bra_pkg::WORD_W-1:0]  q;
  logic                        q_vbit;
  logic [bra_pkg::WORD_W-1:0]  q_word;
  logic                        we;
  logic [bra_pkg::WORD_W-1:0]  wdata;
  logic [bra_pkg::WORD_W-1:0]  bit_mask;

  // scan pipeline
  logic                        issue;
  logic [bra_pkg::CNT_W-1:0]   iss_cnt;
  logic                        rd_v;
  logic [bra_pkg::WADDR_W-1:0] rd_widx;
  logic                        rd_last;
  logic [bra_pkg::WBYTE_LG-1:0] tail;
  logic [bra_pkg::WORD_W-1:0]  scan_word;
  logic [PW-1:0]               wf_first;
  logic [PW-1:0]               wf_top;
  logic                        wf_rhit;
  logic [bra_pkg::WORD_LG-1:0] wf_rpos;
  logic                        ft_v;
  logic                        ft_last;
  logic [bra_pkg::WADDR_W-1:0] ft_widx;
  logic [PW-1:0]               ft_first;
  logic [PW-1:0]               ft_top;
  logic                        ft_rhit;
  logic [bra_pkg::WORD_LG-1:0] ft_rpos;
  logic [bra_pkg::RUN_W-1:0]   run;
  logic                        case_a;
  logic                        hit_now;
  logic [bra_pkg::BIT_W-1:0]   base;
  logic [bra_pkg::BIT_W-1:0]   start_val;
  logic [bra_pkg::BIT_W-1:0]   start_q;
  logic                        found;
  logic                        done;
  logic                        bit_q;

  assign used_eff   = (used_reg > bra_pkg::USED_MAX) ? bra_pkg::USED_MAX : used_reg;
  assign used_round = {1'b0, used_eff} + (bra_pkg::USED_W + 1)'(bra_pkg::WORD_BYTES - 1);
  assign nwords     = bra_pkg::CNT_W'(used_round >> bra_pkg::WBYTE_LG);
  assign oor        = bra_pkg::USED_W'(idx_q[bra_pkg::BIT_W-1:3]) >= used_eff;
  assign idx_word   = idx_q[bra_pkg::WORD_LG +: bra_pkg::WADDR_W];

  assign sts.kind      = kind_q;
  assign sts.oor       = oor;
  assign sts.scan_done = done;
  assign sts.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_reg <= bra_pkg::USED_RESET;
    end else if (cfg_we) begin
      used_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= in_kind;
      idx_q  <= in_bit_index;
      want_q <= in_run_length;
    end
  end

  // ---------------- memory ----------------
  assign raddr    = cmd.scan_run ? iss_cnt[bra_pkg::WADDR_W-1:0] : idx_word;
  assign q_word   = q_vbit ? q : '0;
  assign bit_mask = bra_pkg::WORD_W'(1) << idx_q[bra_pkg::WORD_LG-1:0];
  assign we       = cmd.rmw_write && (kind_q == bra_pkg::KIND_SET || kind_q == bra_pkg::KIND_CLEAR);
  assign wdata    = (kind_q == bra_pkg::KIND_SET) ? (q_word | bit_mask) : (q_word & ~bit_mask);

  always_ff @(posedge clk) begin
    if (we) mem[idx_word] <= wdata;
    q      <= mem[raddr];
    q_vbit <= wvalid[raddr];
  end

  // a word that is not valid reads as all free
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      wvalid <= '0;
    end else if (we) begin
      wvalid[idx_word] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rmw_write) bit_q <= q_word[idx_q[bra_pkg::WORD_LG-1:0]];
  end

  // ---------------- scan pipeline ----------------
  assign issue = cmd.scan_run && !done && !hit_now && (iss_cnt < nwords);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      iss_cnt <= '0;
    end else if (issue) begin
      iss_cnt <= iss_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      rd_v <= 1'b0;
      ft_v <= 1'b0;
    end else begin
      rd_v <= issue;
      ft_v <= rd_v && !hit_now;
    end
  end

  always_ff @(posedge clk) begin
    rd_widx <= iss_cnt[bra_pkg::WADDR_W-1:0];
  end

  // mark bytes past the bytes in use as taken in the last word
  assign rd_last = ({1'b0, rd_widx} == nwords - 1'b1);
  assign tail    = used_eff[bra_pkg::WBYTE_LG-1:0];

  always_comb begin
    scan_word = q_word;
    for (int b = 0; b < bra_pkg::WORD_BYTES; b++) begin
      if (rd_last && tail != '0 && bra_pkg::WBYTE_LG'(b) >= tail) scan_word[b*8 +: 8] = 8'hFF;
    end
  end

  bra_word_scan u_word_scan (
    .word      (scan_word),
    .want      (want_q),
    .first_one (wf_first),
    .top_zeros (wf_top),
    .run_hit   (wf_rhit),
    .run_pos   (wf_rpos)
  );

  always_ff @(posedge clk) begin
    ft_last  <= rd_last;
    ft_widx  <= rd_widx;
    ft_first <= wf_first;
    ft_top   <= wf_top;
    ft_rhit  <= wf_rhit;
    ft_rpos  <= wf_rpos;
  end

  // join the run carried from lower words with this word
  assign base      = {ft_widx, bra_pkg::WORD_LG'(0)};
  assign case_a    = ((bra_pkg::RUN_W + 1)'(run) + (bra_pkg::RUN_W + 1)'(ft_first))
                     >= (bra_pkg::RUN_W + 1)'(want_q);
  assign hit_now   = ft_v && (case_a || ft_rhit);
  assign start_val = case_a ? (base - run[bra_pkg::BIT_W-1:0])
                            : (base + bra_pkg::BIT_W'(ft_rpos));

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      run <= '0;
    end else if (ft_v && !hit_now) begin
      run <= (ft_first == PW'(bra_pkg::WORD_W)) ? (run + bra_pkg::RUN_W'(bra_pkg::WORD_W))
                                                 : bra_pkg::RUN_W'(ft_top);
    end
  end

  always_ff @(posedge clk) begin
    if (hit_now) start_q <= start_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan_start) begin
      done  <= (want_q == '0) || (used_eff == '0);
      found <= 1'b0;
    end else if (hit_now) begin
      done  <= 1'b1;
      found <= 1'b1;
    end else if (ft_v && ft_last) begin
      done  <= 1'b1;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (kind_q) inside
        bra_pkg::KIND_SEARCH: begin
          out_status      <= found ? bra_pkg::ST_OK : bra_pkg::ST_NOFIT;
          out_start_index <= found ? start_q : '0;
          out_bit_read    <= 1'b0;
        end
        bra_pkg::KIND_SET, bra_pkg::KIND_CLEAR, bra_pkg::KIND_TEST: begin
          out_status      <= oor ? bra_pkg::ST_RANGE : bra_pkg::ST_OK;
          out_start_index <= '0;
          out_bit_read    <= (kind_q == bra_pkg::KIND_TEST) && !oor && bit_q;
        end
        default: begin
          out_status      <= bra_pkg::ST_OK;
          out_start_index <= '0;
          out_bit_read    <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/bitmap_run_allocator_top.sv */
// Top level of the bitmap run allocator: controller, datapath and channel glue.
// Uses bra_pkg, bra_ifs, bra_ctrl and bra_datapath.
//
//   channel | dir | modport | payload
//   req     | in  | sink    | kind, bit_index, run_length
//   rsp     | out | source  | status, start_index, bit_read
//   cfg     | in  | sink    | bytes_in_use (always ready)
//
// One item at a time. A search reads the map one 64-bit word per cycle through
// the single memory read port and ends early when a run is found or the length is zero.
// Set, clear and test pass through dispatch, modify and reply (an index out of range
// skips modify), clear all and the undefined kinds go from dispatch to reply; the next
// item can be taken in the cycle after the result is emitted. Reset clears the per-word
// valid bits, which make the map read as all free, with no clearing pass. A result waits
// in the output register while the next item is taken; a stalled output holds the
// controller only when a second result is ready.
`default_nettype none

module bitmap_run_allocator_top (
  input  logic      clk,
  input  logic      rst,
  bra_req_if.sink   req,
  bra_rsp_if.source rsp,
  bra_cfg_if.sink   cfg
);

  bra_pkg::cmd_t cmd;
  bra_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bra_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (req.kind),
    .in_bit_index    (req.bit_index),
    .in_run_length   (req.run_length),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.bytes_in_use),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_start_index (rsp.start_index),
    .out_bit_read    (rsp.bit_read)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while previous item in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(rsp.valid && !rsp.ready))
    else $error("result register loaded while still occupied");

  a_clean_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != bra_pkg::ST_OK) |-> (rsp.start_index == '0 && !rsp.bit_read))
    else $error("failed item carries nonzero result fields");

  a_emit_after_work: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $past(!(req.valid && req.ready)))
    else $error("result emitted in the cycle after accept");

endmodule

`default_nettype wire
